// File: rtl/trimmed_mean_pressure_sensor_assert.svh
// ----------------------------------------------------------------------------
// Trimmed-mean pressure sensor assertion macros
// Shorthand for clocked implication checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_PRESSURE_SENSOR_ASSERT_SVH
`define TRIMMED_MEAN_PRESSURE_SENSOR_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted
`define TMPS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tmps check failed (same cycle)");

// Next-cycle implication, masked while reset is asserted
`define TMPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tmps check failed (next cycle)");

`endif

// File: rtl/tmps_pkg.sv
// ----------------------------------------------------------------------------
// tmps_pkg
// Shared types, field widths, command codes and scaling constants.
// ----------------------------------------------------------------------------
package tmps_pkg;

    localparam int CMD_W     = 2;
    localparam int SAMPLE_W  = 12;
    localparam int NET_W     = 13;
    localparam int VOLT_W    = 19;
    localparam int PRES_W    = 14;

    // Divider operand widths
    localparam int DIVISOR_W = 12;
    localparam int DIVA_W    = 31;  // window sum or average * 330000
    localparam int DIVP_W    = 23;  // |net| * 2000

    localparam int VOLT_SCALE = 330000;
    localparam int FULL_SCALE = 4095;
    localparam int PRES_SCALE = 2000;
    localparam int PRES_DIV   = 1517;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ZERO    = 2'd2;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_MEASURE,
        OP_ZERO
    } tmps_op_kind_t;

    typedef struct packed {
        tmps_op_kind_t         op;
        logic [SAMPLE_W-1:0]   sample;
    } tmps_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV_AVG,
        ST_SCALE_MUL,
        ST_SCALE_GO,
        ST_SCALE_WAIT,
        ST_OUTPUT
    } tmps_state_t;

endpackage

// File: rtl/tmps_div.sv
// ----------------------------------------------------------------------------
// tmps_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tmps_div #(
    parameter int DVD_W = 31
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [DVD_W-1:0]               dividend,
    input  logic [tmps_pkg::DIVISOR_W-1:0] divisor,
    output logic                           busy,
    output logic [DVD_W-1:0]               quotient
);
    import tmps_pkg::*;

    localparam int STEPS = (DVD_W + 1) / 2;
    localparam int QW    = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [QW-1:0]        quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic [DIVISOR_W:0]   r1;
    logic [DIVISOR_W:0]   r2;
    logic                 b1;
    logic                 b2;

    always_comb begin
        r1 = {rem_reg, quo_reg[QW-1]};
        b1 = (r1 >= {1'b0, dvs_reg});
        if (b1) begin
            r1 = r1 - {1'b0, dvs_reg};
        end
        r2 = {r1[DIVISOR_W-1:0], quo_reg[QW-2]};
        b2 = (r2 >= {1'b0, dvs_reg});
        if (b2) begin
            r2 = r2 - {1'b0, dvs_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(STEPS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= QW'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[QW-3:0], b1, b2};
            rem_reg <= r2[DIVISOR_W-1:0];
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg[DVD_W-1:0];

endmodule

// File: rtl/tmps_front.sv
// ----------------------------------------------------------------------------
// tmps_front
// Input handshake and command decode; drops transactions that need no work.
// ----------------------------------------------------------------------------
module tmps_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tmps_pkg::CMD_W-1:0]    s_cmd,
    input  logic [tmps_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                          enabled,
    input  logic                          q_full,
    output logic                          q_push,
    output tmps_pkg::tmps_item_t          q_item
);
    import tmps_pkg::*;

    logic accept;
    logic keep;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        keep          = 1'b0;
        q_item.op     = OP_SAMPLE;
        q_item.sample = s_sample;
        case (s_cmd)
            CMD_SAMPLE: begin
                keep      = 1'b1;
                q_item.op = OP_SAMPLE;
            end
            CMD_MEASURE: begin
                // drop a measure while the sensor is stopped
                keep      = enabled;
                q_item.op = OP_MEASURE;
            end
            CMD_ZERO: begin
                keep      = 1'b1;
                q_item.op = OP_ZERO;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = accept && keep;

endmodule

// File: rtl/tmps_queue.sv
// ----------------------------------------------------------------------------
// tmps_queue
// Short FIFO of decoded operations between the front end and the engine.
// ----------------------------------------------------------------------------
module tmps_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tmps_pkg::tmps_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output tmps_pkg::tmps_item_t pop_item
);
    import tmps_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tmps_item_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/tmps_back.sv
// ----------------------------------------------------------------------------
// tmps_back
// Sample window, min/max/sum scan, division and scaling, result register.
// ----------------------------------------------------------------------------
module tmps_back #(
    parameter int WINDOW_SIZE = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  tmps_pkg::tmps_item_t                q_item,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tmps_pkg::SAMPLE_W-1:0]       m_average,
    output logic signed [tmps_pkg::NET_W-1:0]   m_net_count,
    output logic [tmps_pkg::VOLT_W-1:0]         m_voltage_centi_mv,
    output logic signed [tmps_pkg::PRES_W-1:0]  m_pressure_centigram
);
    import tmps_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_SIZE);
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_SIZE);

    tmps_state_t state_reg;
    tmps_state_t state_next;

    logic [SAMPLE_W-1:0]    win_mem [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] vld_reg;
    logic [IDX_W-1:0]       slot_reg;

    logic [CNT_W-1:0]       cnt_reg;
    logic [SAMPLE_W-1:0]    rd_data_reg;
    logic                   rd_ok_reg;
    logic                   rd_pend_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_W-1:0]    hi_reg;
    logic [SAMPLE_W-1:0]    lo_reg;
    logic                   zero_op_reg;

    logic [SAMPLE_W-1:0]    avg_reg;
    logic [SAMPLE_W-1:0]    off_reg;
    logic signed [NET_W-1:0] net_reg;
    logic                   neg_reg;
    logic [DIVA_W-1:0]      vprod_reg;
    logic [DIVP_W-1:0]      pprod_reg;

    logic                   m_valid_reg;
    logic [SAMPLE_W-1:0]    m_average_reg;
    logic signed [NET_W-1:0] m_net_reg;
    logic [VOLT_W-1:0]      m_volt_reg;
    logic signed [PRES_W-1:0] m_pres_reg;

    logic                   win_we;
    logic                   scan_start;
    logic                   rd_en;
    logic                   avg_load;
    logic                   out_load;
    logic                   diva_start;
    logic                   divp_start;
    logic [DIVA_W-1:0]      diva_dvd;
    logic [DIVISOR_W-1:0]   diva_dvs;
    logic                   diva_busy;
    logic                   divp_busy;
    logic [DIVA_W-1:0]      diva_quo;
    logic [DIVP_W-1:0]      divp_quo;

    logic [SUM_W-1:0]       trimmed;
    logic [SAMPLE_W-1:0]    rd_val;
    logic signed [NET_W-1:0] net_calc;
    logic [SAMPLE_W-1:0]    net_mag;
    logic [PRES_W-1:0]      pres_mag;

    assign trimmed = sum_reg - SUM_W'(hi_reg) - SUM_W'(lo_reg);
    assign rd_val  = rd_ok_reg ? rd_data_reg : '0;

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        win_we     = 1'b0;
        scan_start = 1'b0;
        rd_en      = 1'b0;
        avg_load   = 1'b0;
        out_load   = 1'b0;
        diva_start = 1'b0;
        divp_start = 1'b0;
        diva_dvd   = vprod_reg;
        diva_dvs   = DIVISOR_W'(FULL_SCALE);
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_item.op)
                        OP_SAMPLE: begin
                            win_we = 1'b1;
                        end
                        OP_MEASURE, OP_ZERO: begin
                            scan_start = 1'b1;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                diva_dvd = DIVA_W'(trimmed);
                diva_dvs = DIVISOR_W'(WINDOW_SIZE - 2);
                if (cnt_reg < CNT_W'(WINDOW_SIZE)) begin
                    rd_en = 1'b1;
                end else if (!rd_pend_reg) begin
                    diva_start = 1'b1;
                    state_next = ST_DIV_AVG;
                end
            end
            ST_DIV_AVG: begin
                if (!diva_busy) begin
                    avg_load   = 1'b1;
                    state_next = zero_op_reg ? ST_IDLE : ST_SCALE_MUL;
                end
            end
            ST_SCALE_MUL: begin
                state_next = ST_SCALE_GO;
            end
            ST_SCALE_GO: begin
                diva_start = 1'b1;
                divp_start = 1'b1;
                state_next = ST_SCALE_WAIT;
            end
            ST_SCALE_WAIT: begin
                if (!diva_busy && !divp_busy) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- sample window ----------------
    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[slot_reg] <= q_item.sample;
        end
        if (rd_en) begin
            rd_data_reg <= win_mem[cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            slot_reg    <= '0;
            rd_pend_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end else begin
            rd_pend_reg <= rd_en;
            if (rd_en) begin
                rd_ok_reg <= vld_reg[cnt_reg[IDX_W-1:0]];
            end
            if (win_we) begin
                vld_reg[slot_reg] <= 1'b1;
                if (slot_reg == IDX_W'(WINDOW_SIZE - 1)) begin
                    slot_reg <= '0;
                end else begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
        end
    end

    // ---------------- scan accumulators ----------------
    always_ff @(posedge aclk) begin
        if (scan_start) begin
            cnt_reg     <= '0;
            sum_reg     <= '0;
            hi_reg      <= '0;
            lo_reg      <= '1;
            zero_op_reg <= (q_item.op == OP_ZERO);
        end else begin
            if (rd_en) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (rd_pend_reg) begin
                sum_reg <= sum_reg + SUM_W'(rd_val);
                if (rd_val > hi_reg) begin
                    hi_reg <= rd_val;
                end
                if (rd_val < lo_reg) begin
                    lo_reg <= rd_val;
                end
            end
        end
    end

    // ---------------- average, offset and scaling ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg <= '0;
        end else if (avg_load && zero_op_reg) begin
            off_reg <= diva_quo[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        net_calc = $signed({1'b0, avg_reg}) - $signed({1'b0, off_reg});
        net_mag  = net_calc[NET_W-1] ? SAMPLE_W'(-net_calc) : SAMPLE_W'(net_calc);
    end

    always_ff @(posedge aclk) begin
        if (avg_load) begin
            avg_reg <= diva_quo[SAMPLE_W-1:0];
        end
        if (state_reg == ST_SCALE_MUL) begin
            net_reg   <= net_calc;
            neg_reg   <= net_calc[NET_W-1];
            vprod_reg <= DIVA_W'(avg_reg) * DIVA_W'(VOLT_SCALE);
            pprod_reg <= DIVP_W'(net_mag) * DIVP_W'(PRES_SCALE);
        end
    end

    tmps_div #(
        .DVD_W (DIVA_W)
    ) u_div_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (diva_start),
        .dividend (diva_dvd),
        .divisor  (diva_dvs),
        .busy     (diva_busy),
        .quotient (diva_quo)
    );

    tmps_div #(
        .DVD_W (DIVP_W)
    ) u_div_p (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (divp_start),
        .dividend (pprod_reg),
        .divisor  (DIVISOR_W'(PRES_DIV)),
        .busy     (divp_busy),
        .quotient (divp_quo)
    );

    // ---------------- result register ----------------
    assign pres_mag = divp_quo[PRES_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_average_reg <= avg_reg;
            m_net_reg     <= net_reg;
            m_volt_reg    <= diva_quo[VOLT_W-1:0];
            m_pres_reg    <= neg_reg ? $signed(-pres_mag) : $signed(pres_mag);
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_average            = m_average_reg;
    assign m_net_count          = m_net_reg;
    assign m_voltage_centi_mv   = m_volt_reg;
    assign m_pressure_centigram = m_pres_reg;

endmodule

// File: rtl/trimmed_mean_pressure_sensor.sv
// ----------------------------------------------------------------------------
// trimmed_mean_pressure_sensor
// Trimmed-mean ADC averaging with zero offset, voltage and pressure scaling.
// ----------------------------------------------------------------------------
// Commands enter through a small decode front end into a four-deep queue, so
// the input keeps taking transactions while the engine is busy. A measure or
// zero command scans the window through a single memory read port, then
// divides the trimmed sum in a two-bit-per-cycle divider; a zero command ends
// there. A measure then takes a multiply step and two parallel divisions.
// The finished result sits in an output register, so the engine moves on to
// queued commands while it waits to be taken. Measure commands while the
// enable bit is clear, and command code 3, are taken and dropped. The window
// reads as zero after reset via per-entry valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module trimmed_mean_pressure_sensor #(
    parameter int WINDOW_SIZE = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tmps_pkg::CMD_W-1:0]          s_cmd,
    input  logic [tmps_pkg::SAMPLE_W-1:0]       s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tmps_pkg::SAMPLE_W-1:0]       m_average,
    output logic signed [tmps_pkg::NET_W-1:0]   m_net_count,
    output logic [tmps_pkg::VOLT_W-1:0]         m_voltage_centi_mv,
    output logic signed [tmps_pkg::PRES_W-1:0]  m_pressure_centigram
);
    import tmps_pkg::*;

    logic       enabled_reg;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    tmps_item_t push_item;
    tmps_item_t pop_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
        end else if (cfg_we) begin
            enabled_reg <= cfg_wdata;
        end
    end

    tmps_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .s_sample (s_sample),
        .enabled  (enabled_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    tmps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    tmps_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .q_valid              (q_valid),
        .q_item               (pop_item),
        .q_pop                (q_pop),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_average            (m_average),
        .m_net_count          (m_net_count),
        .m_voltage_centi_mv   (m_voltage_centi_mv),
        .m_pressure_centigram (m_pressure_centigram)
    );

endmodule

// File: rtl/tmps_checker.sv
// ----------------------------------------------------------------------------
// tmps_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "trimmed_mean_pressure_sensor_assert.svh"

module tmps_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [tmps_pkg::SAMPLE_W-1:0]       m_average,
    input logic signed [tmps_pkg::NET_W-1:0]   m_net_count,
    input logic [tmps_pkg::VOLT_W-1:0]         m_voltage_centi_mv,
    input logic signed [tmps_pkg::PRES_W-1:0]  m_pressure_centigram
);
    import tmps_pkg::*;

    // hold a stalled result
    `TMPS_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)
    `TMPS_ASSERT_NEXT(a_hold_pres, aclk, aresetn, m_valid && !m_ready, $stable(m_pressure_centigram))
    // pressure carries the sign of the net count
    `TMPS_ASSERT_IMPLY(a_pres_sign, aclk, aresetn, m_valid, m_net_count[NET_W-1] == m_pressure_centigram[PRES_W-1])
    // a zero average, and only that, gives zero voltage
    `TMPS_ASSERT_IMPLY(a_volt_zero, aclk, aresetn, m_valid, (m_average == '0) == (m_voltage_centi_mv == '0))

endmodule

bind trimmed_mean_pressure_sensor tmps_checker u_tmps_checker (.*);
